// ----- design/ffra_pkg.sv -----
// Shared types and constants for the first-fit range allocator.
// No dependencies.
package ffra_pkg;

  localparam int unsigned MAX_RANGES_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF  = 32;
  localparam logic [31:0] MEM_UNITS_RST  = 32'd65536;

  typedef enum logic [1:0] {
    MODE_CHECK = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_SIZE  = 3'd1,
    STAT_NOGAP = 3'd2,
    STAT_FULL  = 3'd3,
    STAT_NOID  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHK,
    ST_SCAN,
    ST_FIN
  } state_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic shift;  // take the right-hand neighbor's entry
    logic wr_en;  // cell at wr_idx takes the write data
  } cell_ctl_t;

endpackage

// ----- design/ffra_cell.sv -----
// One table entry of the allocator chain: base, end and owner of a range.
// Depends on ffra_pkg.
module ffra_cell import ffra_pkg::*; #(
  parameter int unsigned EW  = ADDR_BITS_DEF,
  parameter int unsigned IW  = 4,
  parameter int unsigned IDX = 0
) (
  input  logic          clk_i,
  input  cell_ctl_t     ctl_i,
  input  logic [IW-1:0] wr_idx_i,
  input  logic [EW-1:0] wr_base_i,
  input  logic [EW-1:0] wr_end_i,
  input  logic [15:0]   wr_owner_i,
  input  logic [EW-1:0] nb_base_i,
  input  logic [EW-1:0] nb_end_i,
  input  logic [15:0]   nb_owner_i,
  output logic [EW-1:0] base_o,
  output logic [EW-1:0] end_o,
  output logic [15:0]   owner_o
);

  logic [EW-1:0] base_q, base_d, end_q, end_d;
  logic [15:0]   owner_q, owner_d;

  always_comb begin
    base_d  = base_q;
    end_d   = end_q;
    owner_d = owner_q;
    if (ctl_i.shift) begin
      base_d  = nb_base_i;
      end_d   = nb_end_i;
      owner_d = nb_owner_i;
    end
    // a write lands after the shift
    if (ctl_i.wr_en && (wr_idx_i == IW'(IDX))) begin
      base_d  = wr_base_i;
      end_d   = wr_end_i;
      owner_d = wr_owner_i;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    end_q   <= end_d;
    owner_q <= owner_d;
  end

  assign base_o  = base_q;
  assign end_o   = end_q;
  assign owner_o = owner_q;

endmodule

// ----- design/ffra_ctrl.sv -----
// Sequencer: rotates the table through the chain head once per request that passes the
// size and table-full checks, doing gap search, insertion and removal on the way. Holds the output beat.
// Depends on ffra_pkg.
module ffra_ctrl import ffra_pkg::*; #(
  parameter int unsigned N  = MAX_RANGES_DEF,
  parameter int unsigned EW = ADDR_BITS_DEF,
  parameter int unsigned IW = $clog2(N),
  parameter int unsigned CW = $clog2(N + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   mem_units_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    mode_i,
  input  logic [15:0]   proc_id_i,
  input  logic [31:0]   proc_size_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          ok_o,
  output logic [2:0]    status_o,
  output logic [31:0]   base_addr_o,
  output logic [31:0]   end_addr_o,
  input  logic [EW-1:0] head_base_i,
  input  logic [EW-1:0] head_end_i,
  input  logic [15:0]   head_owner_i,
  output cell_ctl_t     ctl_o,
  output logic [IW-1:0] wr_idx_o,
  output logic [EW-1:0] wr_base_o,
  output logic [EW-1:0] wr_end_o,
  output logic [15:0]   wr_owner_o
);

  localparam logic [32:0] CAP = (EW >= 32) ? 33'd0 : (33'd1 << EW);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, rem_q, rem_d;
  logic [EW:0]   cursor_q, cursor_d, start_q, start_d;
  logic          found_q, found_d, any_q, any_d;
  mode_e         mode_q, mode_d;
  logic [15:0]   id_q, id_d;
  logic [31:0]   s_q, s_d;
  status_e       stat_q, stat_d;
  logic          ov_q, ov_d, ok_q, ok_d;
  logic [2:0]    os_q, os_d;
  logic [31:0]   ob_q, ob_d, oe_q, oe_d;

  logic [32:0]   size33;
  logic [EW:0]   size_n, s_n, hb_x, he_x;
  logic [CW-1:0] cnt_m1;
  logic          gap_ok, end_ok, is_free;
  logic [31:0]   base32;

  always_comb begin
    if (EW >= 32) size33 = {1'b0, mem_units_i};
    else size33 = ({1'b0, mem_units_i} > CAP) ? CAP : {1'b0, mem_units_i};
  end

  assign size_n  = (EW + 1)'(size33);
  assign s_n     = (EW + 1)'(s_q);
  assign hb_x    = (EW + 1)'(head_base_i);
  assign he_x    = (EW + 1)'(head_end_i);
  assign cnt_m1  = cnt_q - CW'(1);
  assign gap_ok  = (hb_x >= cursor_q) && ((hb_x - cursor_q) >= s_n);
  assign end_ok  = (cursor_q <= size_n) && ((size_n - cursor_q) >= s_n);
  assign is_free = (mode_q == MODE_FREE);
  assign base32  = 32'(start_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    cursor_d  = cursor_q;
    start_d   = start_q;
    found_d   = found_q;
    any_d     = any_q;
    mode_d    = mode_q;
    id_d      = id_q;
    s_d       = s_q;
    stat_d    = stat_q;
    ov_d      = ov_q;
    ok_d      = ok_q;
    os_d      = os_q;
    ob_d      = ob_q;
    oe_d      = oe_q;
    ctl_o     = '0;
    wr_idx_o  = cnt_m1[IW-1:0];
    wr_base_o = head_base_i;
    wr_end_o  = head_end_i;
    wr_owner_o = head_owner_i;
    in_ready_o = (state_q == ST_IDLE);

    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_e'(mode_i);
          id_d    = proc_id_i;
          s_d     = proc_size_i;
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        rem_d    = cnt_q;
        cursor_d = '0;
        start_d  = '0;
        found_d  = 1'b0;
        any_d    = 1'b0;
        state_d  = ST_SCAN;
        if (!is_free) begin
          if ((s_q == 32'd0) || ({1'b0, s_q} > size33)) begin
            stat_d  = STAT_SIZE;
            state_d = ST_FIN;
          end else if ((mode_q == MODE_ALLOC) && (cnt_q >= CW'(N))) begin
            stat_d  = STAT_FULL;
            state_d = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if (rem_q != '0) begin
          if (is_free) begin
            ctl_o.shift = 1'b1;
            rem_d = rem_q - CW'(1);
            if (head_owner_i == id_q) begin
              cnt_d = cnt_m1;
              any_d = 1'b1;
            end else begin
              ctl_o.wr_en = 1'b1;
            end
          end else if (!found_q && gap_ok && (mode_q == MODE_ALLOC)) begin
            // place the new range ahead of the head entry
            found_d     = 1'b1;
            start_d     = cursor_q;
            ctl_o.wr_en = 1'b1;
            wr_idx_o    = cnt_q[IW-1:0];
            wr_base_o   = EW'(cursor_q);
            wr_end_o    = EW'(cursor_q + s_n - (EW + 1)'(1));
            wr_owner_o  = id_q;
            cnt_d       = cnt_q + CW'(1);
          end else begin
            ctl_o.shift = 1'b1;
            ctl_o.wr_en = 1'b1;
            rem_d = rem_q - CW'(1);
            if (!found_q) begin
              if (gap_ok) begin
                found_d = 1'b1;
                start_d = cursor_q;
              end else begin
                cursor_d = he_x + (EW + 1)'(1);
              end
            end
          end
        end else begin
          state_d = ST_FIN;
          if (is_free) begin
            stat_d = any_q ? STAT_OK : STAT_NOID;
          end else if (found_q) begin
            stat_d = STAT_OK;
          end else if (end_ok) begin
            stat_d  = STAT_OK;
            found_d = 1'b1;
            start_d = cursor_q;
            if (mode_q == MODE_ALLOC) begin
              ctl_o.wr_en = 1'b1;
              wr_idx_o    = cnt_q[IW-1:0];
              wr_base_o   = EW'(cursor_q);
              wr_end_o    = EW'(cursor_q + s_n - (EW + 1)'(1));
              wr_owner_o  = id_q;
              cnt_d       = cnt_q + CW'(1);
            end
          end else begin
            stat_d = STAT_NOGAP;
          end
        end
      end
      ST_FIN: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          ok_d = (stat_q == STAT_OK);
          os_d = stat_q;
          if ((stat_q == STAT_OK) && !is_free) begin
            ob_d = base32;
            oe_d = base32 + s_q - 32'd1;
          end else begin
            ob_d = '0;
            oe_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    cursor_q <= cursor_d;
    start_q  <= start_d;
    found_q  <= found_d;
    any_q    <= any_d;
    mode_q   <= mode_d;
    id_q     <= id_d;
    s_q      <= s_d;
    stat_q   <= stat_d;
    ok_q     <= ok_d;
    os_q     <= os_d;
    ob_q     <= ob_d;
    oe_q     <= oe_d;
  end

  assign out_valid_o = ov_q;
  assign ok_o        = ok_q;
  assign status_o    = os_q;
  assign base_addr_o = ob_q;
  assign end_addr_o  = oe_q;

endmodule

// ----- design/first_fit_range_allocator_unit.sv -----
// First-fit range allocator: table of owner-tagged ranges held in a chain of cells.
// Requests that pass the size and table-full checks rotate every entry once past the chain
// head; size or table-full errors skip the rotation. One request at a time; the next is
// taken the cycle after the result is loaded.
// Reset empties the table and sets the memory size to 65536; entries are not cleared.
module first_fit_range_allocator_unit import ffra_pkg::*; #(
  parameter int unsigned MAX_RANGES = MAX_RANGES_DEF,
  parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] proc_id_i,
  input  logic [31:0] proc_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [2:0]  status_o,
  output logic [31:0] base_addr_o,
  output logic [31:0] end_addr_o
);

  localparam int unsigned IW = $clog2(MAX_RANGES);
  localparam int unsigned EW = ADDR_BITS;

  logic [31:0]   mem_units_q;
  cell_ctl_t     ctl;
  logic [IW-1:0] wr_idx;
  logic [EW-1:0] wr_base, wr_end;
  logic [15:0]   wr_owner;
  logic [EW-1:0] c_base [MAX_RANGES];
  logic [EW-1:0] c_end  [MAX_RANGES];
  logic [15:0]   c_owner[MAX_RANGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mem_units_q <= MEM_UNITS_RST;
    else if (cfg_we_i) mem_units_q <= cfg_wdata_i;
  end

  ffra_ctrl #(.N(MAX_RANGES), .EW(EW)) u_ctrl (
    .clk_i, .rst_ni,
    .mem_units_i (mem_units_q),
    .in_valid_i, .in_ready_o, .mode_i, .proc_id_i, .proc_size_i,
    .out_valid_o, .out_ready_i, .ok_o, .status_o, .base_addr_o, .end_addr_o,
    .head_base_i  (c_base[0]),
    .head_end_i   (c_end[0]),
    .head_owner_i (c_owner[0]),
    .ctl_o      (ctl),
    .wr_idx_o   (wr_idx),
    .wr_base_o  (wr_base),
    .wr_end_o   (wr_end),
    .wr_owner_o (wr_owner)
  );

  for (genvar j = 0; j < MAX_RANGES; j++) begin : g_cell
    localparam int unsigned NB = (j == MAX_RANGES - 1) ? j : j + 1;
    ffra_cell #(.EW(EW), .IW(IW), .IDX(j)) u_cell (
      .clk_i,
      .ctl_i      (ctl),
      .wr_idx_i   (wr_idx),
      .wr_base_i  (wr_base),
      .wr_end_i   (wr_end),
      .wr_owner_i (wr_owner),
      .nb_base_i  (c_base[NB]),
      .nb_end_i   (c_end[NB]),
      .nb_owner_i (c_owner[NB]),
      .base_o     (c_base[j]),
      .end_o      (c_end[j]),
      .owner_o    (c_owner[j])
    );
  end

endmodule

// ----- tb/sv/ffra_scoreboard.sv -----
`timescale 1ns / 1ps
// Checker for the first-fit range allocator: watches config, request and result channels,
// keeps a shadow range table, predicts each result and compares it. Depends on ffra_pkg.
module ffra_scoreboard import ffra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  mode_i,
  input  logic [15:0] proc_id_i,
  input  logic [31:0] proc_size_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        ok_i,
  input  logic [2:0]  status_i,
  input  logic [31:0] base_addr_i,
  input  logic [31:0] end_addr_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned SLOTS = MAX_RANGES_DEF;

  typedef struct {
    logic        ok;
    status_e     status;
    logic [31:0] base_addr;
    logic [31:0] end_addr;
  } alloc_result_t;

  alloc_result_t result_q[$];
  logic [31:0] ram_units;
  logic [63:0] tbl_base [SLOTS];
  logic [63:0] tbl_end  [SLOTS];
  logic [15:0] tbl_owner[SLOTS];
  int unsigned tbl_count;
  int          fails = 0;

  assign pending_o    = result_q.size();
  assign fail_count_o = fails;

  task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $time, field, exp_v, got_v);
    fails++;
  endtask

  function automatic void push_result(input status_e st, input logic [63:0] b,
                                      input logic [63:0] e);
    alloc_result_t r;
    r.ok        = (st == STAT_OK);
    r.status    = st;
    r.base_addr = b[31:0];
    r.end_addr  = e[31:0];
    result_q = {result_q, r};
  endfunction

  // first-fit placement and removal over the shadow table
  function automatic void model_request(input logic [1:0] m, input logic [15:0] id,
                                        input logic [31:0] sz);
    logic [63:0] s, lim, cursor, start;
    int unsigned slot, w;
    bit found;
    s = {32'd0, sz};
    lim = {32'd0, ram_units};
    cursor = '0;
    start = '0;
    slot = 0;
    w = 0;
    found = 0;
    if (m == MODE_FREE) begin
      for (int unsigned r = 0; r < tbl_count; r++) begin
        if (tbl_owner[r] == id) begin
          found = 1;
        end else begin
          tbl_base[w] = tbl_base[r];
          tbl_end[w] = tbl_end[r];
          tbl_owner[w] = tbl_owner[r];
          w++;
        end
      end
      tbl_count = w;
      push_result(found ? STAT_OK : STAT_NOID, '0, '0);
    end else if (s == 0 || s > lim) begin
      push_result(STAT_SIZE, '0, '0);
    end else if (m == MODE_ALLOC && tbl_count >= SLOTS) begin
      push_result(STAT_FULL, '0, '0);
    end else begin
      for (int unsigned i = 0; i < tbl_count; i++) begin
        if (!found) begin
          if (tbl_base[i] >= cursor && tbl_base[i] - cursor >= s) begin
            start = cursor;
            slot = i;
            found = 1;
          end else begin
            cursor = tbl_end[i] + 1;
          end
        end
      end
      if (!found && cursor <= lim && lim - cursor >= s) begin
        start = cursor;
        slot = tbl_count;
        found = 1;
      end
      if (!found) begin
        push_result(STAT_NOGAP, '0, '0);
      end else begin
        if (m == MODE_ALLOC) begin
          for (int unsigned k = tbl_count; k > slot; k--) begin
            tbl_base[k] = tbl_base[k-1];
            tbl_end[k] = tbl_end[k-1];
            tbl_owner[k] = tbl_owner[k-1];
          end
          tbl_base[slot] = start;
          tbl_end[slot] = start + s - 1;
          tbl_owner[slot] = id;
          tbl_count++;
        end
        push_result(STAT_OK, start, start + s - 1);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t exp_r;
    if (!rst_ni) begin
      ram_units <= MEM_UNITS_RST;
      tbl_count = 0;
    end else begin
      if (cfg_we_i) ram_units <= cfg_wdata_i;
      if (in_valid_i && in_ready_i) model_request(mode_i, proc_id_i, proc_size_i);
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result beat, status", '0, {29'd0, status_i});
        end else begin
          exp_r = result_q.pop_front();
          if (ok_i !== exp_r.ok) report_mismatch("ok", {31'd0, exp_r.ok}, {31'd0, ok_i});
          if (status_i !== exp_r.status)
            report_mismatch("status", {29'd0, exp_r.status}, {29'd0, status_i});
          if (base_addr_i !== exp_r.base_addr)
            report_mismatch("base_addr", exp_r.base_addr, base_addr_i);
          if (end_addr_i !== exp_r.end_addr)
            report_mismatch("end_addr", exp_r.end_addr, end_addr_i);
        end
      end
    end
  end

endmodule

// ----- tb/sv/tb_first_fit_range_allocator_unit.sv -----
`timescale 1ns / 1ps
// Top of the range allocator testbench: clock, reset, request and config stimulus,
// result backpressure and verdict. Depends on ffra_pkg, the DUT and ffra_scoreboard.
module tb_first_fit_range_allocator_unit;
  import ffra_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = MODE_CHECK;
  logic [15:0] proc_id_i = '0;
  logic [31:0] proc_size_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        ok_o;
  logic [2:0]  status_o;
  logic [31:0] base_addr_o;
  logic [31:0] end_addr_o;

  int fail_count, pending;
  int tx_idle_pct = 14, rx_idle_pct = 45;
  int hold_left = 0, quiet_cycles = 0;
  logic hold_start = 1'b0;
  logic [31:0] cur_ram = MEM_UNITS_RST;

  always #10 clk_i = ~clk_i;

  first_fit_range_allocator_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .mode_i, .proc_id_i, .proc_size_i, .out_valid_o, .out_ready_i,
    .ok_o, .status_o, .base_addr_o, .end_addr_o
  );

  ffra_scoreboard chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_i(in_ready_o),
    .mode_i, .proc_id_i, .proc_size_i, .out_valid_i(out_valid_o), .out_ready_i,
    .ok_i(ok_o), .status_i(status_o), .base_addr_i(base_addr_o), .end_addr_i(end_addr_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // result side backpressure, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_start) begin
      hold_left <= LONG_HOLD;
      out_ready_i <= 1'b0;
    end else if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_req(input mode_e m, input logic [15:0] id, input logic [31:0] sz);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    proc_id_i <= id;
    proc_size_i <= sz;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic set_ram(input logic [31:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    cur_ram = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_size();
    int r;
    logic [31:0] top;
    r = $urandom_range(99);
    top = (cur_ram / 8 == 0) ? 32'd1 : cur_ram / 8;
    if (r < 4) return 32'd0;
    if (r < 9) return $urandom;
    if (r < 12) return cur_ram;
    if (r < 14) return cur_ram + 32'd1;
    return $urandom_range(top, 1);
  endfunction

  function automatic logic [15:0] pick_id();
    if ($urandom_range(99) < 80) return 16'($urandom_range(7));
    return 16'($urandom);
  endfunction

  task automatic random_reqs(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) send_req(MODE_ALLOC, pick_id(), pick_size());
      else if (r < 65) send_req(MODE_FREE, pick_id(), $urandom);
      else if (r < 90) send_req(MODE_CHECK, pick_id(), pick_size());
      else send_req(MODE_RSVD, pick_id(), pick_size());
    end
  endtask

  initial begin
    logic [31:0] ram_list[6];
    ram_list = '{32'd64, 32'd1, 32'hFFFF_FFFF, 32'd1000, $urandom, MEM_UNITS_RST};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: size limits, whole memory, no gap, unknown id, reserved mode
    send_req(MODE_CHECK, 16'h0000, 32'd0);
    send_req(MODE_CHECK, 16'h0001, 32'd65537);
    send_req(MODE_CHECK, 16'h0001, 32'd65536);
    send_req(MODE_FREE, 16'h0005, 32'd0);
    send_req(MODE_ALLOC, 16'hFFFF, 32'd65536);
    send_req(MODE_ALLOC, 16'h0001, 32'd1);
    send_req(MODE_RSVD, 16'h0001, 32'd1);
    send_req(MODE_ALLOC, 16'h0002, 32'hFFFF_FFFF);
    send_req(MODE_FREE, 16'hFFFF, 32'hFFFF_FFFF);
    set_ram(32'd64);
    // fill the table exactly, then overflow, reuse a middle hole
    for (int i = 0; i < 16; i++) send_req(MODE_ALLOC, 16'(i), 32'd4);
    send_req(MODE_ALLOC, 16'h0010, 32'd1);
    send_req(MODE_CHECK, 16'h0010, 32'd1);
    send_req(MODE_FREE, 16'h0003, 32'd0);
    send_req(MODE_ALLOC, 16'h0003, 32'd4);

    for (int p = 0; p < 6; p++) begin
      tx_idle_pct = (p < 2) ? 14 : (p < 4) ? 45 : 0;
      rx_idle_pct = (p < 2) ? 45 : (p < 4) ? 14 : 0;
      set_ram(ram_list[p]);
      if (p == 0) begin
        hold_start <= 1'b1;
        @(posedge clk_i);
        hold_start <= 1'b0;
      end
      random_reqs(150);
      drain();
      random_reqs(150);
    end

    drain();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
design/ffra_pkg.sv
design/ffra_cell.sv
design/ffra_ctrl.sv
design/first_fit_range_allocator_unit.sv
tb/sv/ffra_scoreboard.sv
tb/sv/tb_first_fit_range_allocator_unit.sv
